[sv/btcs_pkg.sv]
// btcs_pkg: shared types and constants of the block transfer chs splitter
// holds sequencer states, status and command codes, register indexes and divider control
// no dependencies
package btcs_pkg;

   // shared divider: left-aligned dividend, narrow divisor, one quotient bit a cycle
   localparam int QUO_W  = 32;
   localparam int DIV_W  = 14;
   localparam int STEP_W = 6;

   // request fields and result fields
   localparam int CMD_W   = 2;
   localparam int LBA_W   = 32;
   localparam int CNT_W   = 7;
   localparam int ADDR_W  = 20;
   localparam int CYL_W   = 16;
   localparam int HEAD_W  = 8;
   localparam int SEC_W   = 6;
   localparam int STS_W   = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SPT       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DMA_CHECK = 2'd3;

   localparam logic [CMD_W-1:0] CMD_READ = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BAD  = 2'd3;

   localparam logic [STS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STS_W-1:0] STS_BAD_CMD  = 2'd1;
   localparam logic [STS_W-1:0] STS_DMA_ZERO = 2'd2;
   localparam logic [STS_W-1:0] STS_CYL_OVF  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CYL_GO,
      ST_CYL_WAIT,
      ST_CLIP,
      ST_HEAD_WAIT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctl_type;

endpackage

[sv/btcs_div.sv]
// btcs_div: shared restoring divider, one quotient bit per cycle
// dividend arrives left-aligned, steps gives its significant width
// depends on btcs_pkg
module btcs_div
   import btcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [QUO_W-1:0]  dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              done,
   output logic [QUO_W-1:0]  quotient,
   output logic [DIV_W-1:0]  remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_W:0]    trial;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = busy_ff && (cnt_ff == STEP_W'(1));
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.steps;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
         quo_in = {quo_ff[QUO_W-2:0], ge};
         // partial remainder stays below the divisor, so it fits DIV_W bits
         rem_in = ge ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[sv/block_transfer_chs_splitter_top.sv]
// block_transfer_chs_splitter_top: splits a block transfer request into chs chunks
// sequencer around one shared bit-serial divider (btcs_div)
// depends on btcs_pkg and btcs_div
//
// A request (start high while busy is low) is offset by the partition start and cut
// into chunks that never cross a cylinder end and, with the dma check on, never
// cross a 64 KiB buffer page. Every chunk is one result strobed on rsp_valid for a
// single cycle; the receiver cannot stall, so results must be taken when shown. A bad
// command or a zero count gives one result right away and busy never rises. Otherwise
// each chunk runs a cylinder divide and then a head divide on the single divider,
// which retires one quotient bit per cycle, sequenced by the go and clip states.
// The dma page clip is a constant multiply, computed combinationally. Busy stays high
// over all chunks of a request; it falls in the cycle that shows the final result,
// and a new request can be taken at the edge ending it.
// Configuration writes are only allowed while busy is low.
module block_transfer_chs_splitter_top
   import btcs_pkg::*;
#(
   parameter int SECTOR_BYTES = 512,
   parameter int MAX_SECTORS  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [LBA_W-1:0]      req_start_sector,
   input  logic [CNT_W-1:0]      req_sector_count,
   input  logic [ADDR_W-1:0]     req_buffer_address,
   output logic                  rsp_valid,
   output logic [CMD_W-1:0]      rsp_operation,
   output logic [CYL_W-1:0]      rsp_cylinder,
   output logic [HEAD_W-1:0]     rsp_head_number,
   output logic [SEC_W-1:0]      rsp_sector_number,
   output logic [CNT_W-1:0]      rsp_chunk_sectors,
   output logic [ADDR_W-1:0]     rsp_chunk_address,
   output logic [CNT_W-1:0]      rsp_total_sectors,
   output logic [STS_W-1:0]      rsp_status,
   output logic                  rsp_last
);

   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SECTORS);
   localparam int               PAGE_W   = 16;
   localparam int               SUM_W    = 21;
   // floor(x / SECTOR_BYTES) for any 16-bit x as one multiply and a shift
   localparam int               PAGE_SHIFT = PAGE_W + $clog2(SECTOR_BYTES);
   localparam int               MUL_W      = PAGE_W + 1;
   localparam int               PROD_W     = PAGE_SHIFT + CNT_W;
   localparam logic [MUL_W-1:0] PAGE_MUL   =
      MUL_W'(((longint'(1) << PAGE_SHIFT) + SECTOR_BYTES - 1) / SECTOR_BYTES);

   // configuration registers
   logic [SEC_W-1:0]  spt_ff;
   logic [HEAD_W-1:0] hds_ff;
   logic [LBA_W-1:0]  offset_ff;
   logic              dma_en_ff;

   // sequencer and request state
   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [LBA_W-1:0]  lba_ff, lba_in;
   logic [CNT_W-1:0]  remaining_ff, remaining_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DIV_W-1:0]  cyl_size_ff, cyl_size_in;
   logic [CYL_W-1:0]  cyl_ff, cyl_in;
   logic [DIV_W-1:0]  within_ff, within_in;
   logic [CNT_W-1:0]  chunk_ff, chunk_in;

   // result register
   logic              emit;
   logic              rsp_valid_ff;
   logic [CMD_W-1:0]  op_ff, op_in;
   logic [CYL_W-1:0]  cyl_out_ff, cyl_out_in;
   logic [HEAD_W-1:0] hd_out_ff, hd_out_in;
   logic [SEC_W-1:0]  sec_out_ff, sec_out_in;
   logic [CNT_W-1:0]  chunk_out_ff, chunk_out_in;
   logic [ADDR_W-1:0] addr_out_ff, addr_out_in;
   logic [CNT_W-1:0]  total_out_ff, total_out_in;
   logic [STS_W-1:0]  sts_out_ff, sts_out_in;
   logic              last_out_ff, last_out_in;

   // shared divider
   div_ctl_type       div_ctl;
   logic [QUO_W-1:0]  div_dividend;
   logic [DIV_W-1:0]  div_divisor;
   logic              div_done;
   logic [QUO_W-1:0]  div_quo;
   logic [DIV_W-1:0]  div_rem;

   logic [SEC_W-1:0]  spt_eff;
   logic [HEAD_W-1:0] hds_eff;
   logic [DIV_W-1:0]  cyl_size_cfg;
   logic [CNT_W-1:0]  cnt_sat;
   logic [SUM_W-1:0]  dma_sum;
   logic              dma_over;
   logic              dma_clip;
   logic [PAGE_W-1:0] page_free;
   logic [PROD_W-1:0] page_prod;
   logic [CNT_W-1:0]  page_fit;
   logic [DIV_W-1:0]  room;
   logic [CNT_W-1:0]  clip_rem;
   logic [CNT_W-1:0]  clip_dma;
   logic [CNT_W-1:0]  rem_after;

   assign spt_eff      = (spt_ff == '0) ? SEC_W'(1) : spt_ff;
   assign hds_eff      = (hds_ff == '0) ? HEAD_W'(1) : hds_ff;
   assign cyl_size_cfg = DIV_W'(spt_eff) * DIV_W'(hds_eff);
   assign cnt_sat      = (req_sector_count > CNT_MAX) ? CNT_MAX : req_sector_count;

   // page overflow test on the whole remaining run
   assign dma_sum  = {{(SUM_W-PAGE_W){1'b0}}, addr_ff[PAGE_W-1:0]}
                   + SUM_W'(remaining_ff * SECTOR_BYTES);
   assign dma_over = |dma_sum[SUM_W-1:PAGE_W];
   assign dma_clip = dma_en_ff && dma_over;

   // sectors that fit before the page end: (0xffff - low) / sector size
   assign page_free = ~addr_ff[PAGE_W-1:0];
   assign page_prod = page_free * PAGE_MUL;
   assign page_fit  = page_prod[PAGE_SHIFT +: CNT_W];

   // sectors left in the cylinder
   assign room     = cyl_size_ff - within_ff;
   assign clip_rem = (DIV_W'(remaining_ff) > room) ? room[CNT_W-1:0] : remaining_ff;
   assign clip_dma = (DIV_W'(page_fit) > room) ? room[CNT_W-1:0] : page_fit;
   assign rem_after = remaining_ff - chunk_ff;

   btcs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      lba_in       = lba_ff;
      remaining_in = remaining_ff;
      total_in     = total_ff;
      addr_in      = addr_ff;
      cyl_size_in  = cyl_size_ff;
      cyl_in       = cyl_ff;
      within_in    = within_ff;
      chunk_in     = chunk_ff;

      emit         = 1'b0;
      op_in        = CMD_READ;
      cyl_out_in   = '0;
      hd_out_in    = '0;
      sec_out_in   = '0;
      chunk_out_in = '0;
      addr_out_in  = addr_ff;
      total_out_in = total_ff;
      sts_out_in   = STS_OK;
      last_out_in  = 1'b1;

      div_ctl      = '0;
      div_dividend = lba_ff;
      div_divisor  = cyl_size_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               addr_out_in  = req_buffer_address;
               total_out_in = '0;
               if (req_cmd == CMD_BAD) begin
                  emit       = 1'b1;
                  sts_out_in = STS_BAD_CMD;
               end else if (cnt_sat == '0) begin
                  emit  = 1'b1;
                  op_in = req_cmd;
               end else begin
                  cmd_in       = req_cmd;
                  lba_in       = req_start_sector + offset_ff;
                  remaining_in = cnt_sat;
                  total_in     = '0;
                  addr_in      = req_buffer_address;
                  cyl_size_in  = cyl_size_cfg;
                  state_in     = ST_CYL_GO;
               end
            end
         end
         ST_CYL_GO: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = STEP_W'(QUO_W);
            state_in      = ST_CYL_WAIT;
         end
         ST_CYL_WAIT: begin
            if (div_done) begin
               if (|div_quo[QUO_W-1:CYL_W]) begin
                  emit       = 1'b1;
                  sts_out_in = STS_CYL_OVF;
                  state_in   = ST_IDLE;
               end else begin
                  cyl_in    = div_quo[CYL_W-1:0];
                  within_in = div_rem;
                  state_in  = ST_CLIP;
               end
            end
         end
         ST_CLIP: begin
            if (dma_clip && (page_fit == '0)) begin
               emit       = 1'b1;
               sts_out_in = STS_DMA_ZERO;
               state_in   = ST_IDLE;
            end else begin
               chunk_in      = dma_clip ? clip_dma : clip_rem;
               div_ctl.start = 1'b1;
               div_dividend  = {within_ff, {(QUO_W-DIV_W){1'b0}}};
               div_divisor   = DIV_W'(spt_eff);
               div_ctl.steps = STEP_W'(DIV_W);
               state_in      = ST_HEAD_WAIT;
            end
         end
         ST_HEAD_WAIT: begin
            if (div_done) begin
               emit         = 1'b1;
               op_in        = cmd_ff;
               cyl_out_in   = cyl_ff;
               hd_out_in    = div_quo[HEAD_W-1:0];
               sec_out_in   = div_rem[SEC_W-1:0] + SEC_W'(1);
               chunk_out_in = chunk_ff;
               total_out_in = total_ff + chunk_ff;
               last_out_in  = (rem_after == '0);
               total_in     = total_ff + chunk_ff;
               remaining_in = rem_after;
               addr_in      = addr_ff + ADDR_W'(chunk_ff * SECTOR_BYTES);
               lba_in       = lba_ff + LBA_W'(chunk_ff);
               state_in     = (rem_after == '0) ? ST_IDLE : ST_CYL_GO;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         spt_ff       <= SEC_W'(9);
         hds_ff       <= HEAD_W'(2);
         offset_ff    <= '0;
         dma_en_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SPT:       spt_ff    <= csr_wdata[SEC_W-1:0];
               CSR_HEADS:     hds_ff    <= csr_wdata[HEAD_W-1:0];
               CSR_OFFSET:    offset_ff <= csr_wdata[LBA_W-1:0];
               CSR_DMA_CHECK: dma_en_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      lba_ff       <= lba_in;
      remaining_ff <= remaining_in;
      total_ff     <= total_in;
      addr_ff      <= addr_in;
      cyl_size_ff  <= cyl_size_in;
      cyl_ff       <= cyl_in;
      within_ff    <= within_in;
      chunk_ff     <= chunk_in;
      if (emit) begin
         op_ff        <= op_in;
         cyl_out_ff   <= cyl_out_in;
         hd_out_ff    <= hd_out_in;
         sec_out_ff   <= sec_out_in;
         chunk_out_ff <= chunk_out_in;
         addr_out_ff  <= addr_out_in;
         total_out_ff <= total_out_in;
         sts_out_ff   <= sts_out_in;
         last_out_ff  <= last_out_in;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_operation     = op_ff;
   assign rsp_cylinder      = cyl_out_ff;
   assign rsp_head_number   = hd_out_ff;
   assign rsp_sector_number = sec_out_ff;
   assign rsp_chunk_sectors = chunk_out_ff;
   assign rsp_chunk_address = addr_out_ff;
   assign rsp_total_sectors = total_out_ff;
   assign rsp_status        = sts_out_ff;
   assign rsp_last          = last_out_ff;

   // an error always closes the request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK) |-> rsp_last)
      else $error("error result without last");

   // a chunk that is not the last one carries sectors
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_chunk_sectors != '0) && (rsp_status == STS_OK))
      else $error("empty intermediate chunk");

   // busy only drops when the final result goes out
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid && rsp_last)
      else $error("request ended without final result");

   // a taken request with a good command and a nonzero count raises busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd != CMD_BAD) && (req_sector_count != '0) |=> busy)
      else $error("request not taken");

endmodule
